// ----- design/zip_central_directory_parser_unit_defines.svh -----
// assertion macros for the zip central directory parser
`ifndef ZIP_CENTRAL_DIRECTORY_PARSER_UNIT_DEFINES_SVH
`define ZIP_CENTRAL_DIRECTORY_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ZCDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zcdp assertion failed");
`define ZCDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zcdp assertion failed");
`else
`define ZCDP_ASSERT_NOW(label, ante, cons)
`define ZCDP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/zcdp_pkg.sv -----
// types and constants shared by the zip central directory parser
`timescale 1ns / 1ps
`default_nettype none

package zcdp_pkg;

    localparam logic [31:0] CD_SIGNATURE  = 32'h02014B50;
    localparam logic [5:0]  HEADER_LEN    = 6'd46;
    localparam logic [5:0]  POS_SIG_LAST  = 6'd3;
    localparam logic [5:0]  POS_METHOD    = 6'd10;
    localparam logic [5:0]  POS_PACKED    = 6'd20;
    localparam logic [5:0]  POS_PLAIN     = 6'd24;
    localparam logic [5:0]  POS_NAME_LEN  = 6'd28;
    localparam logic [5:0]  POS_EXTRA_LEN = 6'd30;
    localparam logic [5:0]  POS_CMT_LEN   = 6'd32;
    localparam logic [5:0]  POS_OFFSET    = 6'd42;
    localparam logic [5:0]  POS_HDR_LAST  = 6'd45;

    localparam logic [1:0]  REG_ENTRY_COUNT = 2'd0;

    localparam logic        STATUS_ENTRY   = 1'b0;
    localparam logic        STATUS_BAD_SIG = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        status;
        logic [15:0] entry_index;
        logic [15:0] method;
        logic [31:0] packed_size;
        logic [31:0] plain_size;
        logic [31:0] local_offset;
        logic [15:0] name_length;
        logic        last_entry;
    } result_t;

    typedef struct packed {
        logic        halted;
        logic [15:0] entries_done;
        logic [5:0]  header_pos;
    } core_status_t;

    function automatic logic [7:0] sig_byte(input logic [1:0] lane);
        return CD_SIGNATURE[{lane, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- design/zcdp_parse_core.sv -----
// record header parser: field capture, trailer skip and result forming
`timescale 1ns / 1ps
`default_nettype none

module zcdp_parse_core
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            data_byte,
    input  wire logic [15:0]           entry_count,
    output zcdp_pkg::result_t          res,
    output zcdp_pkg::core_status_t     stat
);

    logic [5:0]  pos_reg,         pos_next;
    logic [17:0] skip_reg,        skip_next;
    logic [15:0] method_reg,      method_next;
    logic [31:0] packed_reg,      packed_next;
    logic [31:0] plain_reg,       plain_next;
    logic [31:0] offset_reg,      offset_next;
    logic [15:0] name_len_reg,    name_len_next;
    logic [15:0] extra_len_reg,   extra_len_next;
    logic [15:0] cmt_len_reg,     cmt_len_next;
    logic [15:0] done_reg,        done_next;
    logic        sig_bad_reg,     sig_bad_next;
    logic        halted_reg,      halted_next;

    logic        active;
    logic        emit_entry;
    logic        emit_error;
    logic        sig_bad_now;
    logic [5:0]  rel;
    logic [17:0] skip_sum;
    logic [16:0] idx_plus;

    assign active   = !halted_reg && (done_reg < entry_count);
    assign skip_sum = {2'b00, name_len_reg} + {2'b00, extra_len_reg} + {2'b00, cmt_len_reg};
    assign idx_plus = {1'b0, done_reg} + 17'd1;

    always_comb
    begin
        pos_next       = pos_reg;
        skip_next      = skip_reg;
        method_next    = method_reg;
        packed_next    = packed_reg;
        plain_next     = plain_reg;
        offset_next    = offset_reg;
        name_len_next  = name_len_reg;
        extra_len_next = extra_len_reg;
        cmt_len_next   = cmt_len_reg;
        done_next      = done_reg;
        sig_bad_next   = sig_bad_reg;
        halted_next    = halted_reg;
        emit_entry     = 1'b0;
        emit_error     = 1'b0;
        sig_bad_now    = sig_bad_reg;
        rel            = 6'd0;

        if (step && active)
        begin
            if (pos_reg >= zcdp_pkg::HEADER_LEN)
            begin
                // trailer bytes: name, extra field and comment
                skip_next = skip_reg - 18'd1;
                if (skip_reg == 18'd1)
                begin
                    emit_entry = 1'b1;
                end
            end
            else
            begin
                case (pos_reg) inside
                    [6'd0 : zcdp_pkg::POS_SIG_LAST]:
                    begin
                        if (data_byte != zcdp_pkg::sig_byte(pos_reg[1:0]))
                        begin
                            sig_bad_now = 1'b1;
                        end
                        sig_bad_next = sig_bad_now;
                        if (pos_reg == zcdp_pkg::POS_SIG_LAST && sig_bad_now)
                        begin
                            emit_error  = 1'b1;
                            halted_next = 1'b1;
                        end
                    end
                    [zcdp_pkg::POS_METHOD : zcdp_pkg::POS_METHOD + 6'd1]:
                    begin
                        rel = pos_reg - zcdp_pkg::POS_METHOD;
                        method_next[{rel[0], 3'b000} +: 8] = data_byte;
                    end
                    [zcdp_pkg::POS_PACKED : zcdp_pkg::POS_PACKED + 6'd3]:
                    begin
                        rel = pos_reg - zcdp_pkg::POS_PACKED;
                        packed_next[{rel[1:0], 3'b000} +: 8] = data_byte;
                    end
                    [zcdp_pkg::POS_PLAIN : zcdp_pkg::POS_PLAIN + 6'd3]:
                    begin
                        rel = pos_reg - zcdp_pkg::POS_PLAIN;
                        plain_next[{rel[1:0], 3'b000} +: 8] = data_byte;
                    end
                    [zcdp_pkg::POS_NAME_LEN : zcdp_pkg::POS_NAME_LEN + 6'd1]:
                    begin
                        rel = pos_reg - zcdp_pkg::POS_NAME_LEN;
                        name_len_next[{rel[0], 3'b000} +: 8] = data_byte;
                    end
                    [zcdp_pkg::POS_EXTRA_LEN : zcdp_pkg::POS_EXTRA_LEN + 6'd1]:
                    begin
                        rel = pos_reg - zcdp_pkg::POS_EXTRA_LEN;
                        extra_len_next[{rel[0], 3'b000} +: 8] = data_byte;
                    end
                    [zcdp_pkg::POS_CMT_LEN : zcdp_pkg::POS_CMT_LEN + 6'd1]:
                    begin
                        rel = pos_reg - zcdp_pkg::POS_CMT_LEN;
                        cmt_len_next[{rel[0], 3'b000} +: 8] = data_byte;
                    end
                    [zcdp_pkg::POS_OFFSET : zcdp_pkg::POS_HDR_LAST]:
                    begin
                        rel = pos_reg - zcdp_pkg::POS_OFFSET;
                        offset_next[{rel[1:0], 3'b000} +: 8] = data_byte;
                    end
                    default:
                    begin
                        rel = 6'd0;
                    end
                endcase

                if (!emit_error)
                begin
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == zcdp_pkg::POS_HDR_LAST)
                    begin
                        skip_next = skip_sum;
                        if (skip_sum == 18'd0)
                        begin
                            emit_entry = 1'b1;
                        end
                    end
                end
            end
        end

        if (emit_entry)
        begin
            done_next    = idx_plus[15:0];
            pos_next     = 6'd0;
            skip_next    = 18'd0;
            sig_bad_next = 1'b0;
        end
    end

    always_comb
    begin
        res             = '0;
        res.valid       = emit_entry || emit_error;
        res.entry_index = done_reg;
        if (emit_error)
        begin
            res.status = zcdp_pkg::STATUS_BAD_SIG;
        end
        else
        begin
            res.status       = zcdp_pkg::STATUS_ENTRY;
            res.method       = method_next;
            res.packed_size  = packed_next;
            res.plain_size   = plain_next;
            res.local_offset = offset_next;
            res.name_length  = name_len_next;
            res.last_entry   = (idx_plus == {1'b0, entry_count});
        end
    end

    assign stat.halted       = halted_reg;
    assign stat.entries_done = done_reg;
    assign stat.header_pos   = pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            skip_reg      <= '0;
            method_reg    <= '0;
            packed_reg    <= '0;
            plain_reg     <= '0;
            offset_reg    <= '0;
            name_len_reg  <= '0;
            extra_len_reg <= '0;
            cmt_len_reg   <= '0;
            done_reg      <= '0;
            sig_bad_reg   <= 1'b0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            skip_reg      <= skip_next;
            method_reg    <= method_next;
            packed_reg    <= packed_next;
            plain_reg     <= plain_next;
            offset_reg    <= offset_next;
            name_len_reg  <= name_len_next;
            extra_len_reg <= extra_len_next;
            cmt_len_reg   <= cmt_len_next;
            done_reg      <= done_next;
            sig_bad_reg   <= sig_bad_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/zip_central_directory_parser_unit.sv -----
// top level: zip central directory record parser with apb register port
// one byte accepted per cycle while in_ready is high; a result appears in the output register
// in the cycle after the byte that completes a record (or the fourth byte of a bad signature)
// throughput is one byte per cycle while in_ready is high, set by the single-pass capture logic and output register
// rst_n is asynchronous active low and clears all parser state, entry_count and output valid
`timescale 1ns / 1ps
`default_nettype none

`include "zip_central_directory_parser_unit_defines.svh"

module zip_central_directory_parser_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,

    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [7:0]  data_byte,

    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic        status,
    output      logic [15:0] entry_index,
    output      logic [15:0] method,
    output      logic [31:0] packed_size,
    output      logic [31:0] plain_size,
    output      logic [31:0] local_offset,
    output      logic [15:0] name_length,
    output      logic        last_entry
);

    logic [15:0]            entry_count_reg, entry_count_next;
    logic                   out_valid_reg,   out_valid_next;
    zcdp_pkg::result_t      out_reg,         out_next;
    zcdp_pkg::result_t      res;
    zcdp_pkg::core_status_t stat;
    logic                   in_xfer;
    logic                   load;

    assign pready   = 1'b1;
    assign prdata   = (paddr == zcdp_pkg::REG_ENTRY_COUNT) ? {16'd0, entry_count_reg} : 32'd0;
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;
    assign load     = in_xfer && res.valid;

    zcdp_parse_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_xfer),
        .data_byte   (data_byte),
        .entry_count (entry_count_reg),
        .res         (res),
        .stat        (stat)
    );

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (psel && penable && pwrite && pready && paddr == zcdp_pkg::REG_ENTRY_COUNT)
        begin
            entry_count_next = pwdata[15:0];
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign entry_index  = out_reg.entry_index;
    assign method       = out_reg.method;
    assign packed_size  = out_reg.packed_size;
    assign plain_size   = out_reg.plain_size;
    assign local_offset = out_reg.local_offset;
    assign name_length  = out_reg.name_length;
    assign last_entry   = out_reg.last_entry;

    // a signature error stops the parser for good
    `ZCDP_ASSERT_NEXT(a_halt_sticky, stat.halted, stat.halted)
    `ZCDP_ASSERT_NEXT(a_err_halts, load && res.status == zcdp_pkg::STATUS_BAD_SIG, stat.halted)
    // every entry result advances the record count by one and restarts the header
    `ZCDP_ASSERT_NEXT(a_entry_count_step, load && res.status == zcdp_pkg::STATUS_ENTRY,
        stat.entries_done == $past(stat.entries_done) + 16'd1 && stat.header_pos == 6'd0)
    `ZCDP_ASSERT_NOW(a_result_not_dropped, load, in_ready)

endmodule

`default_nettype wire
